FILE: hw/rtl/trce_pkg.sv
`timescale 1ns / 1ps
package trce_pkg;

	localparam int TEXT_DEPTH = 4096;
	localparam int AW         = $clog2(TEXT_DEPTH);
	localparam int MAX_PERIOD = 256;
	localparam int PW         = 9;   // period width
	localparam int CW         = 13;  // count / length width
	localparam int RW         = 17;  // rate width
	localparam int PW_OK_MUL  = 50;  // 1/0.02 acceptance factor

	localparam logic [2:0] REG_TEXT_LENGTH = 3'd0;
	localparam logic [2:0] REG_MM_RATE     = 3'd1;
	localparam logic [2:0] REG_MIN_COPIES  = 3'd2;
	localparam logic [2:0] REG_RESULT_LIM  = 3'd3;

	typedef enum logic [23:0] {
		S_CLEAR    = 24'h000001,
		S_IDLE     = 24'h000002,
		S_LOAD     = 24'h000004,
		S_CHK_RD   = 24'h000008,
		S_CHK      = 24'h000010,
		S_FWD_TEST = 24'h000020,
		S_FWD_RD   = 24'h000040,
		S_FWD_EV   = 24'h000080,
		S_FWD_DEC  = 24'h000100,
		S_BWD_TEST = 24'h000200,
		S_BWD_RD   = 24'h000400,
		S_BWD_EV   = 24'h000800,
		S_BWD_DEC  = 24'h001000,
		S_CNT      = 24'h002000,
		S_P1_NEXT  = 24'h004000,
		S_P1_RD    = 24'h008000,
		S_P1_EV    = 24'h010000,
		S_P2_NEXT  = 24'h020000,
		S_P2_RD    = 24'h040000,
		S_P2_EV    = 24'h080000,
		S_P2_DEC   = 24'h100000,
		S_EMIT     = 24'h200000,
		S_MARK     = 24'h400000,
		S_FINISH   = 24'h800000
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic latch;
		logic load_wr;
		logic cand_init;
		logic fwd_open;
		logic bwd_open;
		logic win_step;
		logic fwd_take;
		logic bwd_take;
		logic p_first;
		logic p_next;
		logic p1_open;
		logic p2_open;
		logic prim_step;
		logic prim_p;
		logic prim_full;
		logic emit;
		logic mark_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_cand;
		logic clr_last;
		logic cand_ok;
		logic fwd_fits;
		logic bwd_fits;
		logic last_i;
		logic neq;
		logic mm_ok;
		logic enough;
		logic p1_more;
		logic j_ok;
		logic p2_more;
		logic p2_ok;
		logic out_free;
		logic mark_last;
	} sts_t;

endpackage

FILE: hw/rtl/trce_if.sv
`timescale 1ns / 1ps
interface trce_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [11:0] text_addr;
	logic [7:0]  text_byte;
	logic        covered_bit;
	logic [11:0] seed_position;
	logic [8:0]  period;
	logic        batch_end;

	modport source (output valid, req_type, text_addr, text_byte, covered_bit,
		seed_position, period, batch_end, input ready);
	modport sink (input valid, req_type, text_addr, text_byte, covered_bit,
		seed_position, period, batch_end, output ready);
endinterface

interface trce_rsp_if;
	logic        valid;
	logic        ready;
	logic [11:0] region_start;
	logic [12:0] region_end;
	logic [8:0]  primitive_period;
	logic [12:0] copy_count;

	modport source (output valid, region_start, region_end, primitive_period,
		copy_count, input ready);
	modport sink (input valid, region_start, region_end, primitive_period,
		copy_count, output ready);
endinterface

FILE: hw/rtl/trce_ctrl.sv
`timescale 1ns / 1ps
module trce_ctrl import trce_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output cmd_t cmd,
	output logic in_ready
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (sts.in_valid) begin
					cmd.latch = 1'b1;
					state_d   = sts.in_cand ? S_CHK_RD : S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load_wr = 1'b1;
				state_d     = S_FINISH;
			end
			S_CHK_RD: state_d = S_CHK;
			S_CHK: begin
				if (sts.cand_ok) begin
					cmd.cand_init = 1'b1;
					state_d       = S_FWD_TEST;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_FWD_TEST: begin
				if (sts.fwd_fits) begin
					cmd.fwd_open = 1'b1;
					state_d      = S_FWD_RD;
				end else begin
					state_d = S_BWD_TEST;
				end
			end
			S_FWD_RD: state_d = S_FWD_EV;
			S_FWD_EV: begin
				cmd.win_step = 1'b1;
				state_d      = sts.last_i ? S_FWD_DEC : S_FWD_RD;
			end
			S_FWD_DEC: begin
				if (sts.mm_ok) begin
					cmd.fwd_take = 1'b1;
					state_d      = S_FWD_TEST;
				end else begin
					state_d = S_BWD_TEST;
				end
			end
			S_BWD_TEST: begin
				if (sts.bwd_fits) begin
					cmd.bwd_open = 1'b1;
					state_d      = S_BWD_RD;
				end else begin
					state_d = S_CNT;
				end
			end
			S_BWD_RD: state_d = S_BWD_EV;
			S_BWD_EV: begin
				cmd.win_step = 1'b1;
				state_d      = sts.last_i ? S_BWD_DEC : S_BWD_RD;
			end
			S_BWD_DEC: begin
				if (sts.mm_ok) begin
					cmd.bwd_take = 1'b1;
					state_d      = S_BWD_TEST;
				end else begin
					state_d = S_CNT;
				end
			end
			S_CNT: begin
				if (sts.enough) begin
					cmd.p_first = 1'b1;
					state_d     = S_P1_NEXT;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_P1_NEXT: begin
				if (sts.p1_more) begin
					cmd.p1_open = 1'b1;
					state_d     = S_P1_RD;
				end else begin
					cmd.p_first = 1'b1;
					state_d     = S_P2_NEXT;
				end
			end
			S_P1_RD: state_d = S_P1_EV;
			S_P1_EV: begin
				if (sts.neq) begin
					cmd.p_next = 1'b1;
					state_d    = S_P1_NEXT;
				end else if (sts.last_i) begin
					if (sts.j_ok) begin
						cmd.prim_p = 1'b1;
						state_d    = S_EMIT;
					end else begin
						cmd.p_next = 1'b1;
						state_d    = S_P1_NEXT;
					end
				end else begin
					cmd.prim_step = 1'b1;
					state_d       = S_P1_RD;
				end
			end
			S_P2_NEXT: begin
				if (sts.p2_more) begin
					cmd.p2_open = 1'b1;
					state_d     = S_P2_RD;
				end else begin
					cmd.prim_full = 1'b1;
					state_d       = S_EMIT;
				end
			end
			S_P2_RD: state_d = S_P2_EV;
			S_P2_EV: begin
				cmd.prim_step = 1'b1;
				state_d       = sts.last_i ? S_P2_DEC : S_P2_RD;
			end
			S_P2_DEC: begin
				if (sts.p2_ok) begin
					cmd.prim_p = 1'b1;
					state_d    = S_EMIT;
				end else begin
					cmd.p_next = 1'b1;
					state_d    = S_P2_NEXT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_MARK;
				end
			end
			S_MARK: begin
				cmd.mark_step = 1'b1;
				if (sts.mark_last) state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

endmodule

FILE: hw/rtl/trce_dp.sv
`timescale 1ns / 1ps
module trce_dp import trce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              in_valid,
	input  logic              in_type,
	input  logic [AW-1:0]     in_addr,
	input  logic [7:0]        in_byte,
	input  logic              in_cov,
	input  logic [AW-1:0]     in_seed,
	input  logic [PW-1:0]     in_period,
	input  logic              in_bend,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_idx,
	input  logic [RW-1:0]     cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [AW-1:0]     out_start,
	output logic [CW-1:0]     out_end,
	output logic [PW-1:0]     out_prim,
	output logic [CW-1:0]     out_copies
);

	logic [CW-1:0] text_length_q, min_copies_q, limit_q, rc_q;
	logic [RW-1:0] rate_q;
	logic [AW-1:0] clr_q;
	logic          out_valid_q;

	logic [AW-1:0] addr_q, seed_q;
	logic [7:0]    byte_q;
	logic          cov_q, bend_q;
	logic [PW-1:0] period_q;

	logic [CW-1:0] pos_q, start_q, copies_q, base_a_q, base_b_q, mark_q;
	logic [PW-1:0] i_q, j_q, p_q, mm_q, prim_q;
	logic [10:0]   max_mm_q;

	logic [7:0]    text_mem_q [TEXT_DEPTH];
	logic          cov_mem_q  [TEXT_DEPTH];
	logic [7:0]    rd_a_q, rd_b_q;
	logic          cov_rd_q;

	logic [AW-1:0] out_start_q;
	logic [CW-1:0] out_end_q, out_copies_q;
	logic [PW-1:0] out_prim_q;

	logic [CW-1:0] n, addr_a, addr_b;
	logic [CW:0]   seed_end, fwd_end;
	logic [26:0]   mm_prod;
	logic [PW-1:0] j_inc;
	logic          cov_we, cov_wd;
	logic [AW-1:0] cov_wa;
	logic [15:0]   mm_x50;

	assign n      = (text_length_q > CW'(TEXT_DEPTH)) ? CW'(TEXT_DEPTH) : text_length_q;
	assign addr_a = base_a_q + CW'(i_q);
	assign addr_b = base_b_q + CW'(j_q);
	assign seed_end = {2'b0, seed_q} + (CW+1)'(period_q);
	assign fwd_end  = {1'b0, pos_q} + (CW+1)'(period_q);
	assign mm_prod  = 27'(period_q) * 27'(rate_q) + 27'h8000;
	assign j_inc    = (j_q + PW'(1) == p_q) ? '0 : j_q + PW'(1);
	assign mm_x50   = 16'(mm_q) * 16'(PW_OK_MUL);

	// config registers, control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_length_q <= CW'(TEXT_DEPTH);
			rate_q        <= '0;
			min_copies_q  <= CW'(2);
			limit_q       <= CW'(4096);
			rc_q          <= '0;
			clr_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_TEXT_LENGTH: text_length_q <= cfg_data[CW-1:0];
					REG_MM_RATE:     rate_q        <= cfg_data;
					REG_MIN_COPIES:  min_copies_q  <= cfg_data[CW-1:0];
					REG_RESULT_LIM:  limit_q       <= cfg_data[CW-1:0];
					default: ;
				endcase
			end
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				rc_q        <= rc_q + CW'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.finish && bend_q) rc_q <= '0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		max_mm_q <= (mm_prod[26:16] == '0) ? 11'd1 : mm_prod[26:16];
		if (cmd.latch) begin
			addr_q   <= in_addr;
			byte_q   <= in_byte;
			cov_q    <= in_cov;
			seed_q   <= in_seed;
			period_q <= in_period;
			bend_q   <= in_bend;
		end
		if (cmd.cand_init) begin
			pos_q    <= seed_end[CW-1:0];
			start_q  <= CW'(seed_q);
			copies_q <= CW'(1);
		end
		if (cmd.fwd_open || cmd.bwd_open) begin
			base_a_q <= cmd.fwd_open ? pos_q : start_q - CW'(period_q);
			base_b_q <= CW'(seed_q);
			i_q      <= '0;
			j_q      <= '0;
			mm_q     <= '0;
		end
		if (cmd.win_step) begin
			mm_q <= mm_q + PW'(rd_a_q != rd_b_q);
			i_q  <= i_q + PW'(1);
			j_q  <= j_q + PW'(1);
		end
		if (cmd.fwd_take) begin
			pos_q    <= pos_q + CW'(period_q);
			copies_q <= copies_q + CW'(1);
		end
		if (cmd.bwd_take) begin
			start_q  <= start_q - CW'(period_q);
			copies_q <= copies_q + CW'(1);
		end
		if (cmd.p_first) p_q <= PW'(1);
		if (cmd.p_next)  p_q <= p_q + PW'(1);
		if (cmd.p1_open || cmd.p2_open) begin
			base_a_q <= start_q;
			base_b_q <= start_q;
			i_q      <= cmd.p1_open ? p_q : '0;
			j_q      <= '0;
			mm_q     <= '0;
		end
		if (cmd.prim_step) begin
			mm_q <= mm_q + PW'(rd_a_q != rd_b_q);
			i_q  <= i_q + PW'(1);
			j_q  <= j_inc;
		end
		if (cmd.prim_p)    prim_q <= p_q;
		if (cmd.prim_full) prim_q <= period_q;
		if (cmd.emit) begin
			out_start_q  <= start_q[AW-1:0];
			out_end_q    <= pos_q;
			out_prim_q   <= prim_q;
			out_copies_q <= copies_q;
			mark_q       <= start_q;
		end
		if (cmd.mark_step) mark_q <= mark_q + CW'(1);
	end

	// text store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.load_wr) text_mem_q[addr_q] <= byte_q;
		rd_a_q <= text_mem_q[addr_a[AW-1:0]];
		rd_b_q <= text_mem_q[addr_b[AW-1:0]];
	end

	always_comb begin
		cov_we = 1'b1;
		cov_wa = mark_q[AW-1:0];
		cov_wd = 1'b1;
		if (cmd.clr_step) begin
			cov_wa = clr_q;
			cov_wd = 1'b0;
		end else if (cmd.load_wr) begin
			cov_wa = addr_q;
			cov_wd = cov_q;
		end else if (!cmd.mark_step) begin
			cov_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cov_we) cov_mem_q[cov_wa] <= cov_wd;
		cov_rd_q <= cov_mem_q[seed_q];
	end

	always_comb begin
		sts.in_valid  = in_valid;
		sts.in_cand   = in_type;
		sts.clr_last  = (clr_q == '1);
		sts.cand_ok   = (period_q != '0) && (period_q <= PW'(MAX_PERIOD)) &&
		                (seed_end <= (CW+1)'(n)) && (rc_q < limit_q) && !cov_rd_q;
		sts.fwd_fits  = (fwd_end <= (CW+1)'(n));
		sts.bwd_fits  = (start_q >= CW'(period_q));
		sts.last_i    = (i_q == period_q - PW'(1));
		sts.neq       = (rd_a_q != rd_b_q);
		sts.mm_ok     = (11'(mm_q) <= max_mm_q);
		sts.enough    = (copies_q >= min_copies_q);
		sts.p1_more   = (p_q < period_q);
		sts.j_ok      = (j_inc == '0);
		sts.p2_more   = (p_q <= (period_q >> 1));
		sts.p2_ok     = (mm_x50 <= 16'(period_q));
		sts.out_free  = !out_valid_q || out_ready;
		sts.mark_last = (mark_q + CW'(1) == pos_q);
	end

	assign out_valid  = out_valid_q;
	assign out_start  = out_start_q;
	assign out_end    = out_end_q;
	assign out_prim   = out_prim_q;
	assign out_copies = out_copies_q;

endmodule

FILE: hw/rtl/tandem_repeat_candidate_engine.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload
// req      in   req_type, text_addr, text_byte, covered_bit, seed_position, period, batch_end
// rsp      out  region_start, region_end, primitive_period, copy_count
// cfg      in   cfg_we, cfg_idx, cfg_data (write only)
//
// One item at a time. A load item writes one text byte and its covered bit. A candidate
// compares each window tried byte by byte, then runs the primitive period trials, then
// marks each position of the region covered; each compare waits on the text RAM reads.
// After reset a pass clears the covered map; req is held off meanwhile.
// A result waits in an output register; the next item is taken while it stalls.
module tandem_repeat_candidate_engine import trce_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	trce_req_if.sink     req,
	trce_rsp_if.source   rsp,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [RW-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	// sequencer: steps windows, period trials and the covered sweep
	trce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	assign req.ready = in_ready;

	// text and covered RAMs, counters, compare logic, result register
	trce_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_valid   (req.valid),
		.in_type    (req.req_type),
		.in_addr    (req.text_addr),
		.in_byte    (req.text_byte),
		.in_cov     (req.covered_bit),
		.in_seed    (req.seed_position),
		.in_period  (req.period),
		.in_bend    (req.batch_end),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_start  (rsp.region_start),
		.out_end    (rsp.region_end),
		.out_prim   (rsp.primitive_period),
		.out_copies (rsp.copy_count)
	);

endmodule

FILE: bench/tandem_repeat_candidate_engine_test.sv
`timescale 1ns / 1ps
module tandem_repeat_candidate_engine_test;
	import trce_pkg::*;

	// generous ceiling on the length of the whole run
	localparam int CYCLE_LIMIT = 8000000;
	localparam int HOLD_CYCLES = 4000;

	typedef struct {
		bit        req_type;
		bit [11:0] addr;
		bit [7:0]  sym;
		bit        cov;
		bit [11:0] seed;
		bit [8:0]  period;
		bit        bend;
	} req_item_t;

	typedef struct {
		bit [11:0] start;
		bit [12:0] stop;
		bit [8:0]  prim;
		bit [12:0] copies;
	} region_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_idx;
	logic [RW-1:0] cfg_data;

	trce_req_if req ();
	trce_rsp_if rsp ();

	tandem_repeat_candidate_engine dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data)
	);

	// shadow copy of the block's state
	bit [7:0]  txt_mirror [TEXT_DEPTH];
	bit        cov_mirror [TEXT_DEPTH];
	int        reported;
	int        text_len_r;
	int        rate_r;
	int        min_copies_r;
	int        limit_r;

	region_t   expected_regions [$];
	int        errors;
	int        regions_seen;
	int        items_sent;
	int        snd_idle;
	int        rcv_idle;
	int        hold_starts;
	int        hold_seen;
	int        hold_left;
	longint    cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off on request so the block backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_starts) begin
			hold_seen <= hold_starts;
			hold_left <= HOLD_CYCLES;
			rsp.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	// Result checker: every transfer on rsp is matched with the oldest expectation.
	always @(posedge clk) begin
		region_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			regions_seen <= regions_seen + 1;
			if (expected_regions.size() == 0) begin
				$error("unexpected result start=%0d end=%0d", rsp.region_start,
					rsp.region_end);
				errors <= errors + 1;
			end else begin
				want = expected_regions.pop_front();
				if (rsp.region_start !== want.start) begin
					$error("region_start expected %0d got %0d", want.start,
						rsp.region_start);
					errors <= errors + 1;
				end
				if (rsp.region_end !== want.stop) begin
					$error("region_end expected %0d got %0d", want.stop, rsp.region_end);
					errors <= errors + 1;
				end
				if (rsp.primitive_period !== want.prim) begin
					$error("primitive_period expected %0d got %0d", want.prim,
						rsp.primitive_period);
					errors <= errors + 1;
				end
				if (rsp.copy_count !== want.copies) begin
					$error("copy_count expected %0d got %0d", want.copies,
						rsp.copy_count);
					errors <= errors + 1;
				end
			end
		end
	end

	function automatic int window_diffs(int pos, int seed, int p);
		int mm;
		mm = 0;
		for (int i = 0; i < p; i++)
			if (txt_mirror[pos + i] != txt_mirror[seed + i])
				mm++;
		return mm;
	endfunction

	// Exact smallest dividing period first; if the motif is primitive, fall back
	// to the first short period within the 2% mismatch allowance.
	function automatic int motif_period(int base, int p);
		bit ok;
		int mm;
		for (int q = 1; q < p; q++) begin
			if (p % q != 0)
				continue;
			ok = 1'b1;
			for (int i = q; i < p; i++)
				if (txt_mirror[base + i] != txt_mirror[base + (i % q)])
					ok = 1'b0;
			if (ok)
				return q;
		end
		for (int q = 1; q <= p / 2; q++) begin
			mm = 0;
			for (int i = 0; i < p; i++)
				if (txt_mirror[base + i] != txt_mirror[base + (i % q)])
					mm++;
			if (PW_OK_MUL * mm <= p)
				return q;
		end
		return p;
	endfunction

	// Apply one accepted item to the shadow state; queue the region it yields.
	function automatic void predict_region(req_item_t it);
		int n, p, seed, start, stop, pos, copies, max_mm;
		longint t;
		region_t r;
		if (!it.req_type) begin
			txt_mirror[it.addr] = it.sym;
			cov_mirror[it.addr] = it.cov;
		end else begin
			n = (text_len_r < TEXT_DEPTH) ? text_len_r : TEXT_DEPTH;
			p = it.period;
			seed = it.seed;
			if (p != 0 && p <= MAX_PERIOD && seed + p <= n && reported < limit_r &&
				!cov_mirror[seed]) begin
				t = longint'(p) * rate_r + 32768;
				max_mm = int'(t >> 16);
				if (max_mm < 1)
					max_mm = 1;
				start = seed;
				stop = seed + p;
				pos = seed + p;
				while (pos + p <= n && window_diffs(pos, seed, p) <= max_mm) begin
					stop = pos + p;
					pos += p;
				end
				while (start >= p && window_diffs(start - p, seed, p) <= max_mm)
					start -= p;
				copies = (stop - start) / p;
				if (copies >= min_copies_r) begin
					r.start = start[11:0];
					r.stop = stop[12:0];
					r.prim = motif_period(start, p);
					r.copies = copies[12:0];
					expected_regions.push_back(r);
					reported = (reported + 1) & 13'h1FFF;
					for (int i = start; i < stop; i++)
						cov_mirror[i] = 1'b1;
				end
			end
		end
		if (it.bend)
			reported = 0;
	endfunction

	task automatic send_item(req_item_t it);
		while ($urandom_range(99) < snd_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= it.req_type;
		req.text_addr <= it.addr;
		req.text_byte <= it.sym;
		req.covered_bit <= it.cov;
		req.seed_position <= it.seed;
		req.period <= it.period;
		req.batch_end <= it.bend;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		predict_region(it);
		items_sent++;
	endtask

	task automatic load_byte(int addr, bit [7:0] sym, bit cov, bit bend = 1'b0);
		req_item_t it;
		it.req_type = 1'b0;
		it.addr = addr[11:0];
		it.sym = sym;
		it.cov = cov;
		it.seed = $urandom();
		it.period = $urandom();
		it.bend = bend;
		send_item(it);
	endtask

	task automatic candidate(int seed, int p, bit bend = 1'b0);
		req_item_t it;
		it.req_type = 1'b1;
		it.addr = $urandom();
		it.sym = $urandom();
		it.cov = $urandom();
		it.seed = seed[11:0];
		it.period = p[8:0];
		it.bend = bend;
		send_item(it);
	endtask

	// sender stops offering until every predicted region has come out
	task automatic wait_results_done();
		req.valid <= 1'b0;
		@(posedge clk);
		while (expected_regions.size() != 0)
			@(posedge clk);
	endtask

	// A trailing load is only taken once any candidate ahead of it is done,
	// so after it the block is idle and safe to reconfigure.
	task automatic settle();
		load_byte(TEXT_DEPTH - 1, txt_mirror[TEXT_DEPTH - 1], cov_mirror[TEXT_DEPTH - 1]);
		wait_results_done();
		repeat (64) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value[RW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TEXT_LENGTH: text_len_r = value & 13'h1FFF;
			REG_MM_RATE:     rate_r = value & 17'h1FFFF;
			REG_MIN_COPIES:  min_copies_r = value & 13'h1FFF;
			REG_RESULT_LIM:  limit_r = value & 13'h1FFF;
			default: ;
		endcase
	endtask

	task automatic set_all(int len, int rate, int minc, int lim);
		write_reg(REG_TEXT_LENGTH, len);
		write_reg(REG_MM_RATE, rate);
		write_reg(REG_MIN_COPIES, minc);
		write_reg(REG_RESULT_LIM, lim);
	endtask

	// Writes copies windows of a p-byte motif at base; mut_pct of bytes mutated.
	// Motif drawn from a small alphabet, sometimes built from a shorter unit.
	task automatic plant_repeat(int base, int p, int copies, int mut_pct);
		bit [7:0] motif [MAX_PERIOD];
		bit [7:0] sym;
		int unit;
		unit = p;
		if ($urandom_range(2) == 0)
			for (int q = 1; q < p; q++)
				if (p % q == 0 && $urandom_range(1)) begin
					unit = q;
					break;
				end
		for (int i = 0; i < p; i++)
			motif[i] = (i < unit) ? 8'(8'h41 + $urandom_range(3)) : motif[i % unit];
		for (int i = 0; i < p * copies && base + i < TEXT_DEPTH; i++) begin
			sym = motif[i % p];
			if ($urandom_range(99) < mut_pct)
				sym = $urandom();
			load_byte(base + i, sym, 1'b0);
		end
	endtask

	task automatic fill_text(bit uniform);
		for (int a = 0; a < TEXT_DEPTH; a++)
			load_byte(a, uniform ? 8'h41 : 8'(8'h41 + $urandom_range(3)),
				uniform ? 1'b0 : ($urandom_range(7) == 0));
	endtask

	task automatic test_whole_text_repeat();
		// uniform text: one period-1 region spans the whole store
		fill_text(1'b1);
		settle();
		write_reg(REG_MIN_COPIES, 4096);
		candidate(0, 1);
		settle();
		write_reg(REG_MIN_COPIES, 2);
		fill_text(1'b0);
		settle();
	endtask

	task automatic test_skips();
		plant_repeat(100, 4, 6, 0);
		candidate(104, 0);             // period zero
		candidate(104, 257);           // period above the maximum
		candidate(104, 511);
		candidate(4095, 2);            // runs past the text end
		candidate(104, 4);             // real region
		candidate(108, 4);             // seed now covered
		load_byte(300, 8'h41, 1'b1);
		candidate(300, 1);             // seed loaded as covered
		plant_repeat(400, 3, 5, 0);
		candidate(400, 3);
		candidate(4090, 6);            // seed plus period exactly at the end
		plant_repeat(600, 5, 1, 0);
		load_byte(605, 8'h5A, 1'b0);
		load_byte(599, 8'h5A, 1'b0);
		candidate(600, 5);             // single copy, too few
		settle();
	endtask

	task automatic test_limits();
		write_reg(REG_RESULT_LIM, 0);
		plant_repeat(800, 2, 4, 0);
		candidate(800, 2);             // limit zero: nothing reported
		settle();
		write_reg(REG_RESULT_LIM, 1);
		plant_repeat(900, 2, 4, 0);
		candidate(800, 2);
		candidate(900, 2);             // limit reached
		load_byte(1000, txt_mirror[1000], 1'b0, 1'b1);   // batch end on a load
		candidate(900, 2, 1'b1);
		plant_repeat(1000, 3, 4, 0);
		candidate(1000, 3);
		settle();
		write_reg(REG_TEXT_LENGTH, 1);
		load_byte(0, 8'h41, 1'b0);
		candidate(0, 1);
		candidate(0, 2);
		settle();
		write_reg(REG_TEXT_LENGTH, 8191);
		write_reg(REG_MIN_COPIES, 1);
		candidate(0, 1, 1'b1);
		settle();
		set_all(4096, 0, 2, 4096);
	endtask

	task automatic test_rates();
		write_reg(REG_MM_RATE, 131071); // rate above one, used as given
		plant_repeat(1200, 4, 3, 30);
		candidate(1204, 4);
		settle();
		write_reg(REG_MM_RATE, 65536);
		plant_repeat(1300, 6, 4, 20);
		candidate(1306, 6);
		settle();
		write_reg(REG_MM_RATE, 3277);
		plant_repeat(1500, 20, 4, 5);
		candidate(1520, 20);
		settle();
		// widest period once with an unmutated motif, then period 128 with a lightly mutated one
		write_reg(REG_MM_RATE, 0);
		plant_repeat(2048, 256, 2, 0);
		candidate(2048, 256);
		settle();
		plant_repeat(3000, 128, 2, 1);
		candidate(3000, 128);
		settle();
	endtask

	task automatic test_random(int sidle, int ridle, bit pressure);
		int base, p, copies, goal_items, goal_regions;
		snd_idle = sidle;
		rcv_idle = ridle;
		goal_items = items_sent + 290;
		goal_regions = regions_seen + 40;
		while ((items_sent < goal_items || regions_seen < goal_regions) &&
			items_sent < goal_items + 3000) begin
			if (pressure && $urandom_range(15) == 0) begin
				hold_starts <= hold_starts + 1;
				pressure = 1'b0;
			end
			if ($urandom_range(9) < 7) begin
				p = ($urandom_range(5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
				copies = $urandom_range(2, 6);
				base = $urandom_range(0, TEXT_DEPTH - p * copies);
				plant_repeat(base, p, copies, $urandom_range(1) ? 0 : 4);
				candidate(base + p * $urandom_range(0, copies - 1),
					($urandom_range(7) == 0) ? p * 2 : p, $urandom_range(9) == 0);
			end else if ($urandom_range(1)) begin
				candidate($urandom(), ($urandom_range(9) == 0) ? $urandom() :
					$urandom_range(0, 12), $urandom_range(7) == 0);
			end else begin
				load_byte($urandom(), $urandom(), $urandom(), $urandom_range(15) == 0);
			end
		end
		if (pressure)
			hold_starts <= hold_starts + 1;
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.req_type = 1'b0;
		req.text_addr = '0;
		req.text_byte = '0;
		req.covered_bit = 1'b0;
		req.seed_position = '0;
		req.period = '0;
		req.batch_end = 1'b0;
		errors = 0;
		regions_seen = 0;
		items_sent = 0;
		hold_starts = 0;
		cycles = 0;
		snd_idle = 0;
		rcv_idle = 0;
		for (int a = 0; a < TEXT_DEPTH; a++) begin
			txt_mirror[a] = '0;
			cov_mirror[a] = 1'b0;
		end
		reported = 0;
		text_len_r = 4096;
		rate_r = 0;
		min_copies_r = 2;
		limit_r = 4096;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_whole_text_repeat();
		test_skips();
		test_limits();
		test_rates();

		set_all(4096, 3277, 2, 4096);
		test_random(22, 86, 1'b0);
		set_all(3000, 6554, 3, 8);
		test_random(86, 22, 1'b0);
		set_all(4096, 0, 1, 4096);
		test_random(0, 0, 1'b1);

		if (errors == 0 && expected_regions.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/trce_pkg.sv
hw/rtl/trce_if.sv
hw/rtl/trce_ctrl.sv
hw/rtl/trce_dp.sv
hw/rtl/tandem_repeat_candidate_engine.sv
bench/tandem_repeat_candidate_engine_test.sv
